[sv/npcs_pkg.sv]
// Package: shared constants, types and codes for the nearest palette color search.
`timescale 1ns / 1ps
package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int INDEX_SPAN      = 256;
  localparam int SEARCH_LIMIT    = (PALETTE_ENTRIES < INDEX_SPAN) ? PALETTE_ENTRIES : INDEX_SPAN;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = $clog2(SEARCH_LIMIT);
  localparam int CHAN_W          = 8;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int DIST_W          = 18;
  localparam int IDX_W           = 8;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } npcs_cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } npcs_pixel_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [CNT_W-1:0] idx;
  } npcs_tag_t;

  typedef struct packed {
    logic [CNT_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } npcs_result_t;

endpackage

[sv/npcs_palette_ram.sv]
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps
module npcs_palette_ram
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  npcs_pixel_t       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output npcs_pixel_t       rdata
);

  npcs_pixel_t mem [PALETTE_ENTRIES];
  npcs_pixel_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/npcs_dist_unit.sv]
// Distance pipeline: squared channel differences, sum, and running minimum.
`timescale 1ns / 1ps
module npcs_dist_unit
  import npcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  npcs_tag_t    rd_tag,
  input  npcs_pixel_t  rd_word,
  input  npcs_pixel_t  pixel,
  output logic         done,
  output npcs_result_t best
);

  npcs_tag_t         tag0_r, tag1_r, tag2_r;
  logic [SQ_W-1:0]   sq_r [4];
  logic [DIST_W-1:0] sum_r;
  npcs_result_t      best_r;
  logic              done_r;
  logic [SQ_W-1:0]   sq_nxt [4];
  logic [DIST_W-1:0] sum_nxt;

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_comb begin
    sq_nxt[0] = chan_sq(rd_word.red,   pixel.red);
    sq_nxt[1] = chan_sq(rd_word.green, pixel.green);
    sq_nxt[2] = chan_sq(rd_word.blue,  pixel.blue);
    sq_nxt[3] = chan_sq(rd_word.alpha, pixel.alpha);
    sum_nxt   = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]) + DIST_W'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
      tag1_r <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag0_r <= rd_tag;
      tag1_r <= tag0_r;
      tag2_r <= tag1_r;
      done_r <= tag2_r.valid && tag2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    sq_r  <= sq_nxt;
    sum_r <= sum_nxt;
    if (tag2_r.valid && (tag2_r.first || (sum_r < best_r.distance))) begin
      best_r.distance <= sum_r;
      best_r.idx      <= tag2_r.idx;
    end
  end

  assign done = done_r;
  assign best = best_r;

endmodule

[sv/nearest_palette_color_search.sv]
// Top level: input handshake, scan sequencer and output word register.
// A query word scans the palette with one read per cycle, then drains through the distance
// pipeline (ST_DRAIN) and is registered in ST_DELIVER; no new word is accepted until the result
// word is registered, and a result word held by out_ready stalls the input.
// A load word is accepted back to back while idle.
// Reset clears control state only; palette content is undefined until loaded.
`timescale 1ns / 1ps
module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [7:0]        in_entry_index,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  input  logic [CHAN_W-1:0] in_alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_best_index,
  output logic [DIST_W-1:0] out_best_distance
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DELIVER
  } state_t;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SEARCH_LIMIT - 1);

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  npcs_pixel_t       pixel_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  logic         in_acc;
  logic         load_we;
  npcs_pixel_t  in_pixel;
  npcs_pixel_t  rd_word;
  npcs_tag_t    rd_tag;
  logic         done;
  npcs_result_t best;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_pixel = '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};
  assign load_we  = in_acc && (in_command == CMD_LOAD) &&
                    ({24'd0, in_entry_index} < 32'(PALETTE_ENTRIES));

  always_comb begin
    rd_tag.valid = (state_r == ST_SCAN);
    rd_tag.first = (cnt_r == '0);
    rd_tag.last  = (cnt_r == LAST_IDX);
    rd_tag.idx   = cnt_r;
  end

  npcs_palette_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (ADDR_W'(in_entry_index)),
    .wdata (in_pixel),
    .re    (rd_tag.valid),
    .raddr (ADDR_W'(cnt_r)),
    .rdata (rd_word)
  );

  npcs_dist_unit u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_tag  (rd_tag),
    .rd_word (rd_word),
    .pixel   (pixel_r),
    .done    (done),
    .best    (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DELIVER)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_command == CMD_QUERY)) begin
            pixel_r <= in_pixel;
            cnt_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state_r <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= IDX_W'(best.idx);
            out_dist_r  <= best.distance;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_best_distance = out_dist_r;

endmodule

[sv/npcs_checker.sv]
// Port checker for the nearest palette color search, bound to the top level.
`timescale 1ns / 1ps
module npcs_checker
  import npcs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] out_best_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_QUERY) |=> !in_ready)
    else $error("input still ready after query accepted");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_LOAD) |=> in_ready)
    else $error("load word stalled the input");

  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while search still busy");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_distance <= DIST_W'(260100)))
    else $error("distance out of range");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_best_distance (out_best_distance)
);

[tb/tb.sv]
// Testbench: self-checking stimulus, predictor and result checks for nearest_palette_color_search.
`timescale 1ns / 1ps
module tb;
  import npcs_pkg::*;

  localparam int LONG_HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES     = SEARCH_LIMIT + 40;
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_ITEMS      = 22;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } match_t;

  typedef enum {FILL_NONE, FILL_ZERO, FILL_RAMP, FILL_RANDOM, FILL_COARSE} palette_fill_t;

  typedef struct {
    bit     given;
    match_t value;
  } answer_t;

  typedef struct {
    palette_fill_t refill;
    npcs_cmd_t     cmd;
    logic [7:0]    slot;
    npcs_pixel_t   pix;
    bit            given;
    match_t        value;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [7:0]        in_entry_index;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;
  logic [CHAN_W-1:0] in_alpha;
  logic              out_valid;
  logic              out_ready;
  logic [IDX_W-1:0]  out_best_index;
  logic [DIST_W-1:0] out_best_distance;

  npcs_pixel_t palette_mirror [PALETTE_ENTRIES];
  npcs_pixel_t loaded_colors [256];
  match_t      pending_results [$];
  answer_t     answer_key [$];
  stim_row_t   directed_rows [$];

  bit long_hold   = 1'b0;
  bit sender_calm = 1'b0;
  int mismatches  = 0;
  int loads_seen  = 0;
  int queries_seen = 0;
  int results_seen = 0;
  int typed_seen  = 0;

  nearest_palette_color_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_best_index    (out_best_index),
    .out_best_distance (out_best_distance)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int channel_sq(logic [7:0] x, logic [7:0] y);
    int d;
    d = int'(x) - int'(y);
    return d * d;
  endfunction

  function automatic int color_distance(npcs_pixel_t p, npcs_pixel_t q);
    return channel_sq(p.red, q.red) + channel_sq(p.green, q.green)
         + channel_sq(p.blue, q.blue) + channel_sq(p.alpha, q.alpha);
  endfunction

  function automatic match_t nearest_entry(npcs_pixel_t q);
    match_t best;
    int d;
    best.index    = '0;
    best.distance = DIST_W'(color_distance(palette_mirror[0], q));
    for (int j = 1; j < SEARCH_LIMIT; j++) begin
      d = color_distance(palette_mirror[j], q);
      if (d < int'(best.distance)) begin
        best.index    = IDX_W'(j);
        best.distance = DIST_W'(d);
      end
    end
    return best;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 24);
    return $urandom_range(60, 400);
  endfunction

  function automatic npcs_pixel_t random_pixel(bit coarse);
    npcs_pixel_t pix;
    pix = $urandom;
    if (coarse) begin
      for (int c = 0; c < 4; c++) pix[8*c +: 8] = 8'($urandom_range(0, 3) * 85);
    end
    return pix;
  endfunction

  function automatic npcs_pixel_t near_color(npcs_pixel_t base);
    npcs_pixel_t pix;
    int v;
    pix = base;
    for (int c = 0; c < 4; c++) begin
      v = int'(base[8*c +: 8]) + int'($urandom_range(0, 6)) - 3;
      pix[8*c +: 8] = 8'((v < 0) ? 0 : ((v > 255) ? 255 : v));
    end
    return pix;
  endfunction

  function automatic void add_row(palette_fill_t refill, npcs_cmd_t cmd, logic [7:0] slot,
                                  logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                                  bit given, logic [IDX_W-1:0] want_index,
                                  logic [DIST_W-1:0] want_distance);
    stim_row_t row;
    row.refill         = refill;
    row.cmd            = cmd;
    row.slot           = slot;
    row.pix            = {a, b, g, r};
    row.given          = given;
    row.value.index    = want_index;
    row.value.distance = want_distance;
    directed_rows.push_back(row);
  endfunction

  task automatic send_word(npcs_cmd_t cmd, logic [7:0] slot, npcs_pixel_t pix, bit given,
                           match_t value);
    answer_t key;
    int gap;
    key.given = given;
    key.value = value;
    if (cmd == CMD_QUERY) answer_key.push_back(key);
    else loaded_colors[slot] = pix;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= slot;
    in_red         <= pix.red;
    in_green       <= pix.green;
    in_blue        <= pix.blue;
    in_alpha       <= pix.alpha;
    do @(posedge clk); while (!in_ready);
    gap = sender_calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic fill_palette(palette_fill_t how);
    npcs_pixel_t pix;
    logic [7:0] s;
    for (int i = 0; i < 256; i++) begin
      s = 8'(i);
      case (how)
        FILL_ZERO:   pix = '0;
        FILL_RAMP:   pix = {s, s, s, s};
        FILL_COARSE: pix = random_pixel(1'b1);
        default:     pix = random_pixel(1'b0);
      endcase
      send_word(CMD_LOAD, s, pix, 1'b0, '0);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    answer_t key;
    match_t  want;
    if (rst_n && in_valid && in_ready) begin
      if (in_command == CMD_LOAD) begin
        loads_seen++;
        if (int'(in_entry_index) < PALETTE_ENTRIES)
          palette_mirror[in_entry_index] = {in_alpha, in_blue, in_green, in_red};
      end else begin
        queries_seen++;
        key = answer_key.pop_front();
        if (key.given) begin
          typed_seen++;
          pending_results.push_back(key.value);
        end else begin
          pending_results.push_back(nearest_entry({in_alpha, in_blue, in_green, in_red}));
        end
      end
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0d ns: expected no word, actual index %0d distance %0d",
                 $time, out_best_index, out_best_distance);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_best_index !== want.index) begin
          $display("%0d ns: best_index expected %0d, actual %0d",
                   $time, want.index, out_best_index);
          mismatches++;
        end
        if (out_best_distance !== want.distance) begin
          $display("%0d ns: best_distance expected %0d, actual %0d",
                   $time, want.distance, out_best_distance);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    int hold;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        long_hold <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500) : $urandom_range(1, 40);
        repeat (hold) @(posedge clk);
        hold = idle_gap();
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    npcs_pixel_t pix;
    logic [7:0]  slot;
    bit          coarse;
    int          pick;

    in_valid       <= 1'b0;
    in_command     <= CMD_LOAD;
    in_entry_index <= '0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    in_alpha       <= '0;
    rst_n          <= 1'b0;

    add_row(FILL_ZERO, CMD_QUERY, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 18'd260100);
    add_row(FILL_NONE, CMD_QUERY, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 18'd0);
    add_row(FILL_NONE, CMD_LOAD, 8'd200, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 8'd200, 18'd0);
    add_row(FILL_NONE, CMD_LOAD, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_LOAD, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 1'b0, '0, '0);
    // tie between two neighbors: lowest index wins
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd10, 8'd11, 8'd10, 8'd11, 1'b1, 8'd10, 18'd2);
    add_row(FILL_NONE, CMD_LOAD, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_LOAD, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1, 8'd127, 18'd65026);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_LOAD, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 18'd0);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd1, 18'd0);
    add_row(FILL_NONE, CMD_LOAD, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd1, 8'd2, 8'd3, 8'd4, 1'b1, 8'd255, 18'd0);
    add_row(FILL_NONE, CMD_QUERY, 8'hAA, 8'd3, 8'd200, 8'd77, 8'd1, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_LOAD, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_LOAD, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, '0, '0);
    add_row(FILL_NONE, CMD_QUERY, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1, 8'h55, 18'd0);
    add_row(FILL_NONE, CMD_QUERY, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 8'hAA, 18'd0);
    add_row(FILL_NONE, CMD_QUERY, 8'h00, 8'd1, 8'd2, 8'd3, 8'd4, 1'b0, '0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.refill != FILL_NONE) fill_palette(row.refill);
      send_word(row.cmd, row.slot, row.pix, row.given, row.value);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      coarse = phase[0];
      // hold the output while words keep coming back to back
      if (phase == 1) begin
        long_hold   <= 1'b1;
        sender_calm = 1'b1;
      end
      if (phase == 4) sender_calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 16) sender_calm = 1'b0;
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_for_results();
        pick = $urandom_range(0, 99);
        slot = 8'($urandom);
        if (pick < 40) begin
          send_word(CMD_LOAD, slot, random_pixel(coarse), 1'b0, '0);
        end else begin
          if (pick < 65) pix = random_pixel(1'b0);
          else if (pick < 88) pix = near_color(loaded_colors[8'($urandom)]);
          else pix = random_pixel(1'b1);
          send_word(CMD_QUERY, slot, pix, 1'b0, '0);
        end
      end
      sender_calm = 1'b0;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d queries, from a zeroed palette through random loads.",
             loads_seen, queries_seen);
    $display("Compared %0d results (%0d against hand-worked answers), with a long output hold-off.",
             results_seen, typed_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
